// ===== rtl/core/gcev_pkg.sv =====
// ----------------------------------------------------------------------------
// gcev_pkg
// Shared types, sizes and the stick response table for the gamepad change
// event generator.
// ----------------------------------------------------------------------------
package gcev_pkg;

	localparam int NUM_BUTTONS = 12;
	localparam int NUM_AXES    = 4;
	localparam int NUM_IN_AXES = 4;                        // axis fields on the poll
	localparam int NUM_EV      = NUM_AXES + NUM_BUTTONS;   // max events per poll
	localparam int EVW         = $clog2(NUM_EV);
	localparam int IDX_W       = 4;
	localparam int QDEPTH      = 2;
	localparam int QPW         = $clog2(QDEPTH);

	localparam logic KIND_AXIS   = 1'b0;
	localparam logic KIND_BUTTON = 1'b1;

	typedef struct packed {
		logic [11:0] button_bits;
		logic [7:0]  left_x;
		logic [7:0]  left_y;
		logic [7:0]  right_x;
		logic [7:0]  right_y;
	} poll_item_t;

	typedef struct packed {
		logic               event_kind;
		logic [IDX_W-1:0]   event_index;
		logic signed [15:0] event_value;
		logic               last_event;
	} evt_item_t;

	// one classified poll waiting for the back end
	typedef struct packed {
		logic [NUM_AXES-1:0][7:0] axes;
		logic [NUM_BUTTONS-1:0]   buttons;
		logic [NUM_EV-1:0]        pend;    // axes in the low bits, then buttons
	} job_t;

	typedef logic signed [15:0] resp_rom_t [256];

	localparam longint unsigned YMAX = 64'd32767;

	function automatic int unsigned bit_len(longint unsigned v);
		int unsigned n;
		n = 0;
		for (int k = 0; k < 64; k++) begin
			if (v[k]) begin
				n = k + 1;
			end
		end
		return n;
	endfunction

	// round to 24 significant bits, ties to even
	function automatic longint unsigned round24(longint unsigned p);
		int unsigned     len;
		int unsigned     sh;
		longint unsigned q;
		longint unsigned rem;
		longint unsigned half;
		len = bit_len(p);
		if (len <= 24) begin
			return p;
		end
		sh   = len - 24;
		q    = p >> sh;
		rem  = p & ((64'd1 << sh) - 64'd1);
		half = 64'd1 << (sh - 1);
		if (rem > half || (rem == half && q[0])) begin
			q = q + 64'd1;
		end
		return q << sh;
	endfunction

	// i/127 as a single-precision value, scaled by 2^30
	function automatic longint unsigned t_fixed(int unsigned i);
		longint unsigned n;
		longint unsigned q;
		longint unsigned r;
		longint unsigned low;
		longint unsigned half;
		longint unsigned hi;
		int unsigned     len;
		int unsigned     sh;
		if (i == 0) begin
			return 64'd0;
		end
		n    = longint'(i) << 40;
		q    = n / 127;
		r    = n % 127;
		len  = bit_len(q);
		sh   = len - 24;
		hi   = q >> sh;
		low  = q & ((64'd1 << sh) - 64'd1);
		half = 64'd1 << (sh - 1);
		if (low > half || (low == half && r != 0) || (low == half && r == 0 && hi[0])) begin
			hi = hi + 64'd1;
		end
		return (hi << sh) >> 10;
	endfunction

	function automatic longint unsigned lerp_y(longint unsigned a, longint unsigned b,
			longint unsigned t);
		longint unsigned prod;
		longint unsigned sum;
		prod = round24((b - a) * t);
		sum  = round24((a << 30) + prod);
		return sum >> 30;
	endfunction

	function automatic resp_rom_t build_rom();
		resp_rom_t       r;
		longint unsigned t;
		longint unsigned bc;
		longint unsigned abbc;
		longint unsigned bccd;
		longint unsigned y;
		for (int i = 0; i < 128; i++) begin
			t    = t_fixed(i);
			bc   = lerp_y(64'd0, YMAX, t);
			abbc = lerp_y(64'd0, bc, t);
			bccd = lerp_y(bc, YMAX, t);
			y    = lerp_y(abbc, bccd, t);
			r[128 + i] = 16'(y);
			r[127 - i] = -(16'(y));
		end
		return r;
	endfunction

	// stick response curve, worked out at elaboration
	localparam resp_rom_t RESP_ROM = build_rom();

endpackage

// ===== rtl/core/gcev_front.sv =====
// ----------------------------------------------------------------------------
// gcev_front
// Takes poll beats, compares them against the stored previous poll and
// hands a change mask plus the new values to the queue.
// ----------------------------------------------------------------------------
module gcev_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                poll_valid,
	output logic                poll_ready,
	input  gcev_pkg::poll_item_t poll,
	input  logic                q_ready,
	output logic                q_push,
	output gcev_pkg::job_t      q_job
);
	import gcev_pkg::*;

	logic [NUM_IN_AXES-1:0][7:0] fld;
	logic [NUM_AXES-1:0][7:0]    axes;
	logic [NUM_BUTTONS-1:0]      buttons;
	logic [NUM_AXES-1:0][7:0]    prev_axes_q;
	logic [NUM_BUTTONS-1:0]      prev_buttons_q;
	logic [NUM_AXES-1:0]         ax_chg;
	logic                        take;

	assign fld = {poll.right_y, poll.right_x, poll.left_y, poll.left_x};

	for (genvar k = 0; k < NUM_AXES; k++) begin : g_axis
		if (k < NUM_IN_AXES) begin : g_fld
			assign axes[k] = fld[k];
		end else begin : g_zero
			assign axes[k] = '0;
		end
		assign ax_chg[k] = (axes[k] != prev_axes_q[k]);
	end

	assign buttons    = NUM_BUTTONS'(poll.button_bits);
	assign poll_ready = q_ready;
	assign take       = poll_valid && poll_ready;

	assign q_job.axes    = axes;
	assign q_job.buttons = buttons;
	assign q_job.pend    = {buttons ^ prev_buttons_q, ax_chg};
	// a poll with no change produces no events and never enters the queue
	assign q_push        = take && (|q_job.pend);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_axes_q    <= '0;
			prev_buttons_q <= '0;
		end else if (take) begin
			prev_axes_q    <= axes;
			prev_buttons_q <= buttons;
		end
	end

endmodule

// ===== rtl/core/gcev_queue.sv =====
// ----------------------------------------------------------------------------
// gcev_queue
// Short FIFO of classified polls between the front and the back end.
// ----------------------------------------------------------------------------
module gcev_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  gcev_pkg::job_t push_job,
	output logic           push_ready,
	input  logic           pop,
	output logic           pop_valid,
	output gcev_pkg::job_t pop_job
);
	import gcev_pkg::*;

	job_t           mem_q [QDEPTH];
	logic [QPW-1:0] wptr_q;
	logic [QPW-1:0] rptr_q;
	logic [QPW:0]   cnt_q;
	logic           do_push;
	logic           do_pop;

	assign push_ready = (cnt_q != (QPW+1)'(QDEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_job    = mem_q[rptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == QPW'(QDEPTH-1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == QPW'(QDEPTH-1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/gcev_back.sv =====
// ----------------------------------------------------------------------------
// gcev_back
// Walks the change mask of one poll, lowest bit first, one event per cycle
// while the output is not stalled, into an output register.
// ----------------------------------------------------------------------------
module gcev_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 job_valid,
	output logic                 job_pop,
	input  gcev_pkg::job_t       job,
	output logic                 evt_valid,
	input  logic                 evt_ready,
	output gcev_pkg::evt_item_t  evt
);
	import gcev_pkg::*;

	job_t              cur_q;
	logic              cur_valid_q;
	evt_item_t         evt_q;
	logic              evt_valid_q;
	logic [NUM_EV-1:0] sel_oh;
	logic [NUM_EV-1:0] rest;
	logic [EVW-1:0]    sel;
	logic [7:0]        axis_raw;
	logic              btn;
	logic              kind;
	logic              advance;
	logic              finish;
	evt_item_t         nxt;

	// isolate lowest pending bit: axes come before buttons
	assign sel_oh  = cur_q.pend & (~cur_q.pend + NUM_EV'(1));
	assign rest    = cur_q.pend & ~sel_oh;
	assign advance = cur_valid_q && (!evt_valid_q || evt_ready);
	assign finish  = advance && (rest == '0);
	assign job_pop = job_valid && (!cur_valid_q || finish);

	always_comb begin
		sel      = '0;
		axis_raw = '0;
		for (int k = NUM_EV - 1; k >= 0; k--) begin
			if (sel_oh[k]) begin
				sel = EVW'(k);
			end
		end
		for (int k = 0; k < NUM_AXES; k++) begin
			axis_raw = axis_raw | (cur_q.axes[k] & {8{sel_oh[k]}});
		end
	end

	assign btn  = |(sel_oh[NUM_EV-1:NUM_AXES] & cur_q.buttons);
	assign kind = (|sel_oh[NUM_AXES-1:0]) ? KIND_AXIS : KIND_BUTTON;

	always_comb begin
		nxt.event_kind  = kind;
		nxt.event_index = (kind == KIND_BUTTON) ? IDX_W'(sel - EVW'(NUM_AXES)) : IDX_W'(sel);
		nxt.event_value = (kind == KIND_BUTTON) ? 16'(btn) : RESP_ROM[axis_raw];
		nxt.last_event  = (rest == '0);
	end

	always_ff @(posedge clk) begin
		if (job_pop) begin
			cur_q <= job;
		end else if (advance) begin
			cur_q.pend <= rest;
		end
		if (advance) begin
			evt_q <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			evt_valid_q <= 1'b0;
		end else begin
			if (job_pop) begin
				cur_valid_q <= 1'b1;
			end else if (finish) begin
				cur_valid_q <= 1'b0;
			end
			if (advance) begin
				evt_valid_q <= 1'b1;
			end else if (evt_ready) begin
				evt_valid_q <= 1'b0;
			end
		end
	end

	assign evt_valid = evt_valid_q;
	assign evt       = evt_q;

endmodule

// ===== rtl/core/gamepad_change_event_generator_top.sv =====
// The first event of a poll passes the poll queue, the back-end job register and
// the output register. Throughput: one event beat per cycle while evt_ready is high,
// up to 16 (axes + buttons) per poll; a poll with no change gives none at all.
// Polls are taken every cycle while the 2-entry poll queue has room.
// Reset: previous buttons and axes clear to zero, queue and outputs empty.
// ----------------------------------------------------------------------------
// gamepad_change_event_generator_top
// Emits axis and button change events for each gamepad poll.
// ----------------------------------------------------------------------------
module gamepad_change_event_generator_top (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 poll_valid,
	output logic                 poll_ready,
	input  gcev_pkg::poll_item_t poll,
	output logic                 evt_valid,
	input  logic                 evt_ready,
	output gcev_pkg::evt_item_t  evt
);
	import gcev_pkg::*;

	logic q_push;
	logic q_ready;
	logic q_pop;
	logic q_valid;
	job_t q_in;
	job_t q_out;

	gcev_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.poll_valid(poll_valid),
		.poll_ready(poll_ready),
		.poll      (poll),
		.q_ready   (q_ready),
		.q_push    (q_push),
		.q_job     (q_in)
	);

	gcev_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_job  (q_in),
		.push_ready(q_ready),
		.pop       (q_pop),
		.pop_valid (q_valid),
		.pop_job   (q_out)
	);

	gcev_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_valid(q_valid),
		.job_pop  (q_pop),
		.job      (q_out),
		.evt_valid(evt_valid),
		.evt_ready(evt_ready),
		.evt      (evt)
	);

	// queued jobs always carry at least one change
	assert property (@(posedge clk) disable iff (!arst_n)
		q_valid |-> (q_out.pend != '0))
		else $error("empty change mask in queue");

	assert property (@(posedge clk) disable iff (!arst_n)
		(evt_valid && evt.event_kind == KIND_BUTTON) |->
		((evt.event_value == 16'sd0 || evt.event_value == 16'sd1) &&
		 evt.event_index < IDX_W'(NUM_BUTTONS)))
		else $error("bad button event");

	assert property (@(posedge clk) disable iff (!arst_n)
		(evt_valid && evt.event_kind == KIND_AXIS) |->
		(evt.event_value != -16'sd32768 && evt.event_index < IDX_W'(NUM_AXES)))
		else $error("bad axis event");

endmodule
